FILE: rtl/rsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and codes of the RESP stream parser.
// ----------------------------------------------------------------------------
package rsp_pkg;

    // event codes
    localparam logic [2:0] EV_FRAME  = 3'd0;
    localparam logic [2:0] EV_OPEN   = 3'd1;
    localparam logic [2:0] EV_HEADER = 3'd2;
    localparam logic [2:0] EV_DATA   = 3'd3;
    localparam logic [2:0] EV_CLOSE  = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    // element kinds
    localparam logic [2:0] KIND_ARRAY  = 3'd0;
    localparam logic [2:0] KIND_BULK   = 3'd1;
    localparam logic [2:0] KIND_RDB    = 3'd2;
    localparam logic [2:0] KIND_SIMPLE = 3'd3;
    localparam logic [2:0] KIND_SERR   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_TYPE = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_DEPTH    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_SIMPLE_LIMIT = 2'd0;
    localparam logic [1:0] REG_MAX_NESTING  = 2'd1;

    // protocol characters
    localparam logic [7:0] CH_ARRAY  = 8'h2A;
    localparam logic [7:0] CH_BULK   = 8'h24;
    localparam logic [7:0] CH_SIMPLE = 8'h2B;
    localparam logic [7:0] CH_SERR   = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [15:0] SIMPLE_LIMIT_RST = 16'd1024;
    localparam logic [3:0]  MAX_NESTING_RST  = 4'd8;

    // one result, without the end-of-run mark
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  element_type;
        logic [7:0]  payload;
        logic [30:0] header_length;
        logic [3:0]  nest_level;
        logic [3:0]  closed_ancestors;
        logic        message_done;
        logic [2:0]  error_code;
    } t_result;

    // all results of one byte, slot 0 first
    typedef struct packed {
        t_result [2:0] res;
        logic [1:0]    cnt;
    } t_bundle;

    function automatic t_result mk_result(
        input logic [2:0]  ev,
        input logic [2:0]  kind,
        input logic [7:0]  pay,
        input logic [30:0] hlen,
        input logic [3:0]  nest,
        input logic [3:0]  anc,
        input logic        done,
        input logic [2:0]  err
    );
        t_result r;
        r.event_res        = ev;
        r.element_type     = kind;
        r.payload          = pay;
        r.header_length    = hlen;
        r.nest_level       = nest;
        r.closed_ancestors = anc;
        r.message_done     = done;
        r.error_code       = err;
        return r;
    endfunction

endpackage

FILE: rtl/rsp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_core
// Parser state, array count stack and per-byte result generation.
// ----------------------------------------------------------------------------
module rsp_core #(
    parameter int MAX_DEPTH   = 8,
    parameter int LENGTH_BITS = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output rsp_pkg::t_bundle o_bundle
);

    localparam int LW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEN, PH_LEN_LF, PH_BULK_DATA, PH_BULK_CR, PH_BULK_LF, PH_SIMPLE
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [16:0]            r_sidx, n_sidx;
    logic                   r_pcr, n_pcr;
    logic [2:0]             r_kind, n_kind;
    logic [LW-1:0]          r_level, n_level;
    logic [LENGTH_BITS-1:0] r_stack [MAX_DEPTH];
    logic [15:0]            r_limit;
    logic [3:0]             r_nesting;

    logic [MAX_DEPTH-1:0]   le1;
    logic [LW-1:0]          c_anc, c_level;
    logic                   run;
    logic [LENGTH_BITS+3:0] acc10;
    logic                   acc_ovf;
    logic                   do_push, do_close, do_type, faulted;
    rsp_pkg::t_bundle       bun;

    // close unit: pop every top entry that this close completes
    always_comb begin
        run   = 1'b1;
        c_anc = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            le1[i] = (r_stack[i] <= LENGTH_BITS'(1));
        end
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            if (LW'(i) < r_level) begin
                if (run && le1[i]) begin
                    c_anc = c_anc + LW'(1);
                end else begin
                    run = 1'b0;
                end
            end
        end
        c_level = r_level - c_anc;
    end

    // decimal length accumulate
    assign acc10   = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + (LENGTH_BITS + 4)'(i_byte[3:0]);
    assign acc_ovf = (acc10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0);

    // per-byte results and next state
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_left   = r_left;
        n_sidx   = r_sidx;
        n_pcr    = r_pcr;
        n_kind   = r_kind;
        n_level  = r_level;
        do_push  = 1'b0;
        do_close = 1'b0;
        do_type  = 1'b0;
        faulted  = 1'b0;
        bun      = '0;

        unique case (r_phase)
            PH_LEN: begin
                if (i_byte >= rsp_pkg::CH_ZERO && i_byte <= rsp_pkg::CH_NINE) begin
                    if (acc_ovf) begin
                        faulted = 1'b1;
                        bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_ERROR, n_kind, 8'd0,
                            31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_LENGTH);
                    end else begin
                        n_acc = acc10[LENGTH_BITS-1:0];
                        bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_FRAME, n_kind, 8'd0,
                            31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                    end
                end else if (i_byte == rsp_pkg::CH_CR) begin
                    n_phase = PH_LEN_LF;
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_FRAME, n_kind, 8'd0,
                        31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                end else begin
                    faulted = 1'b1;
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_ERROR, n_kind, 8'd0,
                        31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_LENGTH);
                end
                bun.cnt = bun.cnt + 2'd1;
            end
            PH_LEN_LF: begin
                if (i_byte != rsp_pkg::CH_LF || r_acc == '0) begin
                    faulted = 1'b1;
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_ERROR, n_kind, 8'd0,
                        31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_LENGTH);
                end else begin
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_HEADER, n_kind, 8'd0,
                        31'(r_acc), 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                    if (r_kind == rsp_pkg::KIND_ARRAY) begin
                        if (r_level < LW'(MAX_DEPTH)) begin
                            do_push = 1'b1;
                            n_level = r_level + LW'(1);
                        end
                        n_phase = PH_IDLE;
                    end else begin
                        n_left  = r_acc;
                        n_phase = PH_BULK_DATA;
                    end
                end
                bun.cnt = bun.cnt + 2'd1;
            end
            PH_BULK_DATA: begin
                bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_DATA, n_kind, i_byte,
                    31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                bun.cnt = bun.cnt + 2'd1;
                if (r_left <= LENGTH_BITS'(1)) begin
                    n_left  = '0;
                    n_phase = PH_BULK_CR;
                end else begin
                    n_left = r_left - LENGTH_BITS'(1);
                end
            end
            PH_BULK_CR, PH_BULK_LF: begin
                if (r_phase == PH_BULK_CR && i_byte == rsp_pkg::CH_CR) begin
                    n_phase = PH_BULK_LF;
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_FRAME, n_kind, 8'd0,
                        31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                end else begin
                    // a bulk string not followed by cr lf closes as rdb
                    do_close = 1'b1;
                    do_type  = !(r_phase == PH_BULK_LF && i_byte == rsp_pkg::CH_LF);
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_CLOSE,
                        do_type ? rsp_pkg::KIND_RDB : rsp_pkg::KIND_BULK, 8'd0, 31'd0,
                        4'(r_level), 4'(c_anc), (c_level == '0), rsp_pkg::ERR_NONE);
                    n_level = c_level;
                    n_phase = PH_IDLE;
                    n_kind  = rsp_pkg::KIND_ARRAY;
                end
                bun.cnt = bun.cnt + 2'd1;
            end
            PH_SIMPLE: begin
                if (r_pcr && i_byte == rsp_pkg::CH_LF) begin
                    do_close = 1'b1;
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_CLOSE, r_kind, 8'd0,
                        31'd0, 4'(r_level), 4'(c_anc), (c_level == '0), rsp_pkg::ERR_NONE);
                    n_level = c_level;
                    n_phase = PH_IDLE;
                    n_kind  = rsp_pkg::KIND_ARRAY;
                end else if (r_sidx > {1'b0, r_limit}) begin
                    faulted = 1'b1;
                    bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_ERROR, n_kind, 8'd0,
                        31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_OVERFLOW);
                end else begin
                    // a cr is framing, anything else is content
                    if (i_byte == rsp_pkg::CH_CR) begin
                        bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_FRAME, n_kind, 8'd0,
                            31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                    end else begin
                        bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_DATA, n_kind, i_byte,
                            31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
                    end
                    n_sidx = r_sidx + 17'd1;
                    n_pcr  = (i_byte == rsp_pkg::CH_CR);
                end
                bun.cnt = bun.cnt + 2'd1;
            end
            default: begin
                n_phase = PH_IDLE;
                do_type = 1'b1;
            end
        endcase

        // type byte, also the byte that broke a bulk terminator
        if (do_type) begin
            n_acc = '0;
            if (i_byte == rsp_pkg::CH_ARRAY) begin
                n_kind = rsp_pkg::KIND_ARRAY;
                if (32'(n_level) >= 32'(r_nesting)
                        || n_level >= LW'(MAX_DEPTH)) begin
                    faulted = 1'b1;
                end else begin
                    n_phase = PH_LEN;
                end
            end else if (i_byte == rsp_pkg::CH_BULK) begin
                n_kind  = rsp_pkg::KIND_BULK;
                n_phase = PH_LEN;
            end else if (i_byte == rsp_pkg::CH_SIMPLE || i_byte == rsp_pkg::CH_SERR) begin
                n_kind  = (i_byte == rsp_pkg::CH_SIMPLE) ? rsp_pkg::KIND_SIMPLE
                                                         : rsp_pkg::KIND_SERR;
                n_phase = PH_SIMPLE;
                n_sidx  = '0;
                n_pcr   = 1'b0;
            end else begin
                n_kind  = rsp_pkg::KIND_ARRAY;
                faulted = 1'b1;
            end
            if (faulted) begin
                bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_ERROR, rsp_pkg::KIND_ARRAY,
                    8'd0, 31'd0, 4'(n_level), 4'd0, 1'b0,
                    (i_byte == rsp_pkg::CH_ARRAY) ? rsp_pkg::ERR_DEPTH
                                                  : rsp_pkg::ERR_BAD_TYPE);
            end else begin
                bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_OPEN, n_kind, 8'd0,
                    31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_NONE);
            end
            bun.cnt = bun.cnt + 2'd1;
        end

        // end of available data
        if (i_end && !faulted) begin
            if (n_phase == PH_BULK_CR || n_phase == PH_BULK_LF) begin
                do_close = 1'b1;
                bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_CLOSE, rsp_pkg::KIND_RDB,
                    8'd0, 31'd0, 4'(r_level), 4'(c_anc), (c_level == '0), rsp_pkg::ERR_NONE);
                bun.cnt = bun.cnt + 2'd1;
                n_level = c_level;
                n_phase = PH_IDLE;
                n_kind  = rsp_pkg::KIND_ARRAY;
            end
            if (n_phase != PH_IDLE || n_level != '0) begin
                faulted = 1'b1;
                bun.res[bun.cnt] = rsp_pkg::mk_result(rsp_pkg::EV_ERROR, n_kind, 8'd0,
                    31'd0, 4'(n_level), 4'd0, 1'b0, rsp_pkg::ERR_BAD_TYPE);
                bun.cnt = bun.cnt + 2'd1;
            end
        end

        // any error drops back to idle with no arrays open
        if (faulted) begin
            n_phase = PH_IDLE;
            n_level = '0;
            n_kind  = rsp_pkg::KIND_ARRAY;
        end
    end

    assign o_bundle = bun;

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_acc     <= '0;
            r_left    <= '0;
            r_sidx    <= '0;
            r_pcr     <= 1'b0;
            r_kind    <= rsp_pkg::KIND_ARRAY;
            r_level   <= '0;
            r_limit   <= rsp_pkg::SIMPLE_LIMIT_RST;
            r_nesting <= rsp_pkg::MAX_NESTING_RST;
        end else begin
            if (i_valid) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_left  <= n_left;
                r_sidx  <= n_sidx;
                r_pcr   <= n_pcr;
                r_kind  <= n_kind;
                r_level <= n_level;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rsp_pkg::REG_SIMPLE_LIMIT: r_limit   <= i_cfg_data;
                    rsp_pkg::REG_MAX_NESTING:  r_nesting <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // remaining element counts, each entry updates itself
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i_valid && do_push && r_level == LW'(i)) begin
                r_stack[i] <= r_acc;
            end else if (i_valid && do_close && c_level != '0
                         && c_level - LW'(1) == LW'(i)) begin
                r_stack[i] <= r_stack[i] - LENGTH_BITS'(1);
            end
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(MAX_DEPTH))
        else $error("nesting level above stack depth");

    a_error_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && faulted) |=> (r_phase == PH_IDLE && r_level == '0))
        else $error("parser not idle after error");

    a_some_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (bun.cnt != 2'd0))
        else $error("byte produced no result");

    a_close_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && do_close && !faulted) |=> (r_level == $past(c_level)))
        else $error("close left wrong level");

endmodule

FILE: rtl/rsp_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_outbuf
// Holds the results of one byte and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module rsp_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rsp_pkg::t_bundle i_bundle,
    input  logic             i_ready,
    output logic             o_valid,
    output rsp_pkg::t_result o_res,
    output logic             o_last,
    output logic             o_can_load
);

    rsp_pkg::t_result [2:0] r_res;
    logic [1:0]             r_cnt;
    logic                   take;

    assign take       = o_valid && i_ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_last     = (r_cnt == 2'd1);
    assign o_res      = r_res[0];
    // room once the final result of the held byte leaves
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    // result slots, shifted down on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end else if (take) begin
            r_res <= {r_res[2], r_res[2:1]};
        end
    end

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("load while results pending");

    a_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt == $past(i_bundle.cnt)))
        else $error("result count not loaded");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_load) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("result count lost a step");

endmodule

FILE: rtl/resp_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_stream_parser
// RESP2 byte stream parser emitting open, header, payload, close and error
// events for arrays, bulk strings, simple strings and simple errors.
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | content
// s_axis   | in        | tvalid / tready        | tdata: data_byte; tlast: end_of_data
// m_axis   | out       | tvalid / tready        | tdata/tuser: result; tlast: last_of_run
// cfg      | in        | i_cfg_valid/o_cfg_ready| index 0 simple_limit, 1 max_nesting
//
// a byte is parsed in the cycle it is taken and its one to three results are
// registered; one result leaves per cycle while tready is high, so bytes with a
// single result stream at one per cycle and later results of a byte hold the
// next byte back. a new byte is taken in the cycle the last held result leaves.
// reset is synchronous; configuration writes are always taken.
// ----------------------------------------------------------------------------
module resp_stream_parser #(
    parameter int MAX_DEPTH   = 8,
    parameter int LENGTH_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // payload, header_length, nest_level,
                                          // closed_ancestors, message_done, error_code
    output logic [5:0]  o_m_axis_tuser,   // event_res, element_type
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    rsp_pkg::t_bundle bundle;
    rsp_pkg::t_result res;
    logic             can_load;
    logic             load;

    assign o_s_axis_tready = can_load;
    assign load            = i_s_axis_tvalid && can_load;
    assign o_cfg_ready     = 1'b1;

    // parser
    rsp_core #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (load),
        .i_byte      (i_s_axis_tdata),
        .i_end       (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bundle    (bundle)
    );

    // result buffer
    rsp_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_bundle   (bundle),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_res      (res),
        .o_last     (o_m_axis_tlast),
        .o_can_load (can_load)
    );

    // output packing
    assign o_m_axis_tuser = {res.element_type, res.event_res};
    assign o_m_axis_tdata = {5'd0, res.error_code, res.message_done, res.closed_ancestors,
                             res.nest_level, res.header_length, res.payload};

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RESP stream parser: a directed table followed
// by random well-formed messages mixed with noise, with both stream sides
// idling at random and several register settings. Each output transfer is
// compared field by field against a behavioural predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH_MAX   = 8;
    localparam longint LEN_TOP = (64'd1 << 31) - 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        P_IDLE, P_LEN, P_LEN_LF, P_BULK_DATA, P_BULK_CR, P_BULK_LF, P_SIMPLE
    } t_phase;

    typedef struct {
        logic [7:0] b;
        logic       l;
        logic       fx;
        logic [2:0] ev;
        logic [2:0] err;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        i_s_axis_tvalid, o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid, i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;
    logic [5:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    resp_stream_parser uut (.*);

    // predictor state
    t_phase      pr_phase;
    longint      pr_accum, pr_left;
    int          pr_sidx, pr_level, pr_cnt;
    bit          pr_cr, pr_fault;
    logic [2:0]  pr_kind;
    longint      pr_stack[DEPTH_MAX];
    int          pr_limit, pr_nest;

    // expected results, oldest first
    rsp_pkg::t_result exp_res_q[$];
    bit               exp_last_q[$];
    logic [7:0]       byte_q[$];

    int  errors = 0, cycles = 0, bytes_sent = 0, results_seen = 0;
    bit  quiet = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("resp_stream_parser verification failed");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    task automatic push_res(input logic [2:0] ev, input logic [2:0] kind,
                            input logic [7:0] pay, input longint hlen,
                            input int anc, input bit done, input logic [2:0] err);
        if (pr_cnt < 3) begin
            exp_res_q.push_back(rsp_pkg::mk_result(ev, kind, pay, hlen[30:0], pr_level[3:0],
                                                   anc[3:0], done, err));
            exp_last_q.push_back(1'b0);
            pr_cnt++;
        end
    endtask

    task automatic raise_error(input logic [2:0] code);
        push_res(rsp_pkg::EV_ERROR, pr_kind, 8'd0, 0, 0, 1'b0, code);
        pr_phase = P_IDLE;
        pr_level = 0;
        pr_kind  = rsp_pkg::KIND_ARRAY;
        pr_fault = 1;
    endtask

    task automatic finish_element(input logic [2:0] kind);
        int nest, anc;
        nest = pr_level;
        anc  = 0;
        while (pr_level > 0) begin
            if (pr_stack[pr_level-1] > 0) pr_stack[pr_level-1]--;
            if (pr_stack[pr_level-1] != 0) break;
            pr_level--;
            anc++;
        end
        if (pr_cnt < 3) begin
            exp_res_q.push_back(rsp_pkg::mk_result(rsp_pkg::EV_CLOSE, kind, 8'd0, 31'd0,
                                                   nest[3:0], anc[3:0], pr_level == 0,
                                                   rsp_pkg::ERR_NONE));
            exp_last_q.push_back(1'b0);
            pr_cnt++;
        end
        pr_phase = P_IDLE;
        pr_kind  = rsp_pkg::KIND_ARRAY;
    endtask

    task automatic open_element(input logic [7:0] b);
        if (b == rsp_pkg::CH_ARRAY) begin
            pr_kind = rsp_pkg::KIND_ARRAY;
            if (pr_level >= pr_nest || pr_level >= DEPTH_MAX) begin
                raise_error(rsp_pkg::ERR_DEPTH);
                return;
            end
            pr_phase = P_LEN;
        end else if (b == rsp_pkg::CH_BULK) begin
            pr_kind  = rsp_pkg::KIND_BULK;
            pr_phase = P_LEN;
        end else if (b == rsp_pkg::CH_SIMPLE || b == rsp_pkg::CH_SERR) begin
            pr_kind  = (b == rsp_pkg::CH_SIMPLE) ? rsp_pkg::KIND_SIMPLE : rsp_pkg::KIND_SERR;
            pr_phase = P_SIMPLE;
            pr_sidx  = 0;
            pr_cr    = 0;
        end else begin
            pr_kind = rsp_pkg::KIND_ARRAY;
            raise_error(rsp_pkg::ERR_BAD_TYPE);
            return;
        end
        pr_accum = 0;
        push_res(rsp_pkg::EV_OPEN, pr_kind, 8'd0, 0, 0, 1'b0, rsp_pkg::ERR_NONE);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic l);
        pr_cnt   = 0;
        pr_fault = 0;
        case (pr_phase)
            P_LEN: begin
                if (b >= rsp_pkg::CH_ZERO && b <= rsp_pkg::CH_NINE) begin
                    pr_accum = pr_accum * 10 + (longint'(b) - longint'(rsp_pkg::CH_ZERO));
                    if (pr_accum > LEN_TOP) raise_error(rsp_pkg::ERR_LENGTH);
                    else push_res(rsp_pkg::EV_FRAME, pr_kind, 8'd0, 0, 0, 1'b0,
                                  rsp_pkg::ERR_NONE);
                end else if (b == rsp_pkg::CH_CR) begin
                    pr_phase = P_LEN_LF;
                    push_res(rsp_pkg::EV_FRAME, pr_kind, 8'd0, 0, 0, 1'b0, rsp_pkg::ERR_NONE);
                end else raise_error(rsp_pkg::ERR_LENGTH);
            end
            P_LEN_LF: begin
                if (b != rsp_pkg::CH_LF || pr_accum == 0) raise_error(rsp_pkg::ERR_LENGTH);
                else begin
                    push_res(rsp_pkg::EV_HEADER, pr_kind, 8'd0, pr_accum, 0, 1'b0,
                             rsp_pkg::ERR_NONE);
                    if (pr_kind == rsp_pkg::KIND_ARRAY) begin
                        if (pr_level < DEPTH_MAX) begin
                            pr_stack[pr_level] = pr_accum;
                            pr_level++;
                        end
                        pr_phase = P_IDLE;
                    end else begin
                        pr_left  = pr_accum;
                        pr_phase = P_BULK_DATA;
                    end
                end
            end
            P_BULK_DATA: begin
                push_res(rsp_pkg::EV_DATA, pr_kind, b, 0, 0, 1'b0, rsp_pkg::ERR_NONE);
                if (pr_left > 0) pr_left--;
                if (pr_left == 0) pr_phase = P_BULK_CR;
            end
            P_BULK_CR: begin
                if (b == rsp_pkg::CH_CR) begin
                    push_res(rsp_pkg::EV_FRAME, pr_kind, 8'd0, 0, 0, 1'b0, rsp_pkg::ERR_NONE);
                    pr_phase = P_BULK_LF;
                end else begin
                    finish_element(rsp_pkg::KIND_RDB);
                    open_element(b);
                end
            end
            P_BULK_LF: begin
                if (b == rsp_pkg::CH_LF) finish_element(rsp_pkg::KIND_BULK);
                else begin
                    finish_element(rsp_pkg::KIND_RDB);
                    open_element(b);
                end
            end
            P_SIMPLE: begin
                if (pr_cr && b == rsp_pkg::CH_LF) finish_element(pr_kind);
                else if (pr_sidx > pr_limit) raise_error(rsp_pkg::ERR_OVERFLOW);
                else begin
                    if (b == rsp_pkg::CH_CR)
                        push_res(rsp_pkg::EV_FRAME, pr_kind, 8'd0, 0, 0, 1'b0,
                                 rsp_pkg::ERR_NONE);
                    else
                        push_res(rsp_pkg::EV_DATA, pr_kind, b, 0, 0, 1'b0, rsp_pkg::ERR_NONE);
                    pr_sidx++;
                    pr_cr = (b == rsp_pkg::CH_CR);
                end
            end
            default: begin
                pr_phase = P_IDLE;
                open_element(b);
            end
        endcase
        if (l && !pr_fault) begin
            if (pr_phase == P_BULK_CR || pr_phase == P_BULK_LF)
                finish_element(rsp_pkg::KIND_RDB);
            if (pr_phase != P_IDLE || pr_level > 0) raise_error(rsp_pkg::ERR_BAD_TYPE);
        end
        if (pr_cnt > 0) exp_last_q[$] = 1'b1;
    endtask

    // ---------------- output side ----------------
    always @(negedge i_clk)
        i_m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);

    always @(posedge i_clk) begin
        rsp_pkg::t_result act;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            act = rsp_pkg::mk_result(o_m_axis_tuser[2:0], o_m_axis_tuser[5:3],
                                     o_m_axis_tdata[7:0], o_m_axis_tdata[38:8],
                                     o_m_axis_tdata[42:39], o_m_axis_tdata[46:43],
                                     o_m_axis_tdata[47], o_m_axis_tdata[50:48]);
            results_seen++;
            if (exp_res_q.size() == 0) begin
                $display("%0t: unexpected result %h last %b", $time, act, o_m_axis_tlast);
                errors++;
            end else begin
                if (act !== exp_res_q[0] || o_m_axis_tlast !== exp_last_q[0]) begin
                    $display("%0t: mismatch expected %h last %b actual %h last %b", $time,
                             exp_res_q[0], exp_last_q[0], act, o_m_axis_tlast);
                    errors++;
                end
                void'(exp_res_q.pop_front());
                void'(exp_last_q.pop_front());
            end
        end
    end

    // ---------------- input side ----------------
    // one byte transfer; valid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic l);
        while (!quiet && $urandom_range(99) < 19) begin
            i_s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1;
        i_s_axis_tdata  = b;
        i_s_axis_tlast  = l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_byte(b, l);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_idle();
        i_s_axis_tvalid = 0;
        while (exp_res_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rsp_pkg::REG_SIMPLE_LIMIT) pr_limit = int'(val);
        else pr_nest = int'(val[3:0]);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic push_decimal(input longint v);
        string s;
        s = $sformatf("%0d", v);
        foreach (s[k]) byte_q.push_back(s[k]);
        byte_q.push_back(rsp_pkg::CH_CR);
        byte_q.push_back(rsp_pkg::CH_LF);
    endtask

    // one random element, well formed apart from occasional breaks
    task automatic gen_element(input int depth);
        int n;
        case ($urandom_range(3))
            0: begin
                if (depth >= 4) begin
                    byte_q.push_back(rsp_pkg::CH_SIMPLE);
                    byte_q.push_back(rsp_pkg::CH_CR);
                    byte_q.push_back(rsp_pkg::CH_LF);
                    return;
                end
                n = $urandom_range(1, 3);
                byte_q.push_back(rsp_pkg::CH_ARRAY);
                push_decimal(n);
                for (int k = 0; k < n; k++) gen_element(depth + 1);
            end
            1: begin
                n = $urandom_range(1, 6);
                byte_q.push_back(rsp_pkg::CH_BULK);
                push_decimal(n);
                repeat (n) byte_q.push_back(8'($urandom_range(255)));
                if ($urandom_range(9) != 0) byte_q.push_back(rsp_pkg::CH_CR);
                if ($urandom_range(9) != 0) byte_q.push_back(rsp_pkg::CH_LF);
            end
            default: begin
                byte_q.push_back($urandom_range(1) ? rsp_pkg::CH_SIMPLE : rsp_pkg::CH_SERR);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    logic [7:0] c;
                    c = 8'($urandom_range(255));
                    if (c == rsp_pkg::CH_LF) c = 8'hFF;
                    byte_q.push_back(c);
                end
                byte_q.push_back(rsp_pkg::CH_CR);
                byte_q.push_back(rsp_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic random_phase(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            byte_q.delete();
            case ($urandom_range(9))
                0: repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(255)));
                1: begin
                    byte_q.push_back($urandom_range(1) ? rsp_pkg::CH_ARRAY : rsp_pkg::CH_BULK);
                    case ($urandom_range(2))
                        0: push_decimal(LEN_TOP);
                        1: push_decimal(LEN_TOP + 1);
                        default: begin
                            byte_q.push_back(rsp_pkg::CH_ZERO);
                            byte_q.push_back(rsp_pkg::CH_CR);
                            byte_q.push_back($urandom_range(1) ? rsp_pkg::CH_LF : 8'h41);
                        end
                    endcase
                end
                default: gen_element(0);
            endcase
            foreach (byte_q[k])
                send_byte(byte_q[k], (k == byte_q.size() - 1) ? ($urandom_range(3) == 0)
                                                              : ($urandom_range(60) == 0));
        end
    endtask

    // directed table: fixed expectations on the last result of marked rows
    t_row dir_tab[] = '{
        '{8'h78, 1, 1, rsp_pkg::EV_ERROR, rsp_pkg::ERR_BAD_TYPE},
        '{rsp_pkg::CH_BULK, 0, 0, 0, 0}, '{rsp_pkg::CH_ZERO, 0, 0, 0, 0},
        '{rsp_pkg::CH_CR, 0, 0, 0, 0},
        '{rsp_pkg::CH_LF, 0, 1, rsp_pkg::EV_ERROR, rsp_pkg::ERR_LENGTH},
        '{rsp_pkg::CH_ARRAY, 0, 0, 0, 0},
        '{rsp_pkg::CH_SERR, 0, 1, rsp_pkg::EV_ERROR, rsp_pkg::ERR_LENGTH},
        '{rsp_pkg::CH_ARRAY, 0, 0, 0, 0}, '{8'h31, 0, 0, 0, 0},
        '{rsp_pkg::CH_CR, 0, 0, 0, 0}, '{rsp_pkg::CH_LF, 0, 0, 0, 0},
        '{rsp_pkg::CH_SIMPLE, 0, 0, 0, 0}, '{8'h41, 0, 0, 0, 0},
        '{rsp_pkg::CH_CR, 0, 0, 0, 0}, '{rsp_pkg::CH_LF, 1, 0, 0, 0},
        '{rsp_pkg::CH_BULK, 0, 0, 0, 0}, '{8'h31, 0, 0, 0, 0},
        '{rsp_pkg::CH_CR, 0, 0, 0, 0}, '{rsp_pkg::CH_LF, 0, 0, 0, 0},
        '{8'hFF, 0, 0, 0, 0}, '{rsp_pkg::CH_SERR, 0, 0, 0, 0},
        '{8'h00, 0, 0, 0, 0}, '{rsp_pkg::CH_CR, 0, 0, 0, 0},
        '{rsp_pkg::CH_LF, 0, 0, 0, 0},
        '{rsp_pkg::CH_BULK, 0, 0, 0, 0}, '{8'h32, 0, 0, 0, 0},
        '{rsp_pkg::CH_CR, 1, 1, rsp_pkg::EV_ERROR, rsp_pkg::ERR_BAD_TYPE}
    };

    initial begin
        i_rst_n = 0;
        i_s_axis_tvalid = 0; i_s_axis_tdata = 0; i_s_axis_tlast = 0;
        i_cfg_valid = 0; i_cfg_index = rsp_pkg::REG_SIMPLE_LIMIT; i_cfg_data = 0;
        i_m_axis_tready = 0;
        pr_phase = P_IDLE; pr_accum = 0; pr_left = 0; pr_sidx = 0; pr_cr = 0;
        pr_kind = rsp_pkg::KIND_ARRAY; pr_level = 0;
        pr_limit = int'(rsp_pkg::SIMPLE_LIMIT_RST);
        pr_nest  = int'(rsp_pkg::MAX_NESTING_RST);
        foreach (pr_stack[k]) pr_stack[k] = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed part
        foreach (dir_tab[k]) begin
            send_byte(dir_tab[k].b, dir_tab[k].l);
            if (dir_tab[k].fx && (exp_res_q.size() == 0 ||
                exp_res_q[$].event_res !== dir_tab[k].ev ||
                exp_res_q[$].error_code !== dir_tab[k].err)) begin
                $display("%0t: table row %0d expected event %0d error %0d", $time, k,
                         dir_tab[k].ev, dir_tab[k].err);
                errors++;
            end
        end
        drain_and_idle();

        // random part over several register settings
        random_phase(60);
        drain_and_idle();
        write_reg(rsp_pkg::REG_SIMPLE_LIMIT, 16'd1);
        write_reg(rsp_pkg::REG_MAX_NESTING, 16'd1);
        random_phase(60);
        drain_and_idle();
        write_reg(rsp_pkg::REG_SIMPLE_LIMIT, 16'hFFFF);
        write_reg(rsp_pkg::REG_MAX_NESTING, 16'd8);
        quiet = 1;
        random_phase(60);
        quiet = 0;
        drain_and_idle();
        write_reg(rsp_pkg::REG_SIMPLE_LIMIT, 16'd4);
        write_reg(rsp_pkg::REG_MAX_NESTING, 16'd2);
        random_phase(60);
        drain_and_idle();
        write_reg(rsp_pkg::REG_SIMPLE_LIMIT, rsp_pkg::SIMPLE_LIMIT_RST);
        write_reg(rsp_pkg::REG_MAX_NESTING, 16'd3);
        random_phase(60);

        drain_and_idle();
        repeat (20) @(negedge i_clk);
        $display("covered %0d input bytes and %0d results over five register settings",
                 bytes_sent, results_seen);
        if (errors == 0 && exp_res_q.size() == 0)
            $display("resp_stream_parser verification clean");
        else
            $display("resp_stream_parser verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/rsp_pkg.sv
rtl/rsp_core.sv
rtl/rsp_outbuf.sv
rtl/resp_stream_parser.sv
bench/tb_top.sv
